// File: sv/mar_pkg.sv
// package for the moving average and rotate block
// types, register indexes and controller states; no dependencies
package mar_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_ACCUM,
        ST_DIVIDE,
        ST_ROT_MUL,
        ST_ROT_SUM,
        ST_DONE
    } state_t;

    localparam logic [2:0] REG_WINDOW = 3'd0;
    localparam logic [2:0] REG_ROT_EN = 3'd1;
    localparam logic [2:0] REG_COS    = 3'd2;
    localparam logic [2:0] REG_SIN    = 3'd3;
    localparam logic [2:0] REG_CTR_RP = 3'd4;
    localparam logic [2:0] REG_CTR_L  = 3'd5;

    localparam int COEF_WIDTH = 16;
    localparam int ROT_SHIFT  = 15;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic ring_write;
        logic read_start;
        logic read_step;
        logic accum;
        logic div_start;
        logic rot_mul;
        logic rot_sum;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic read_last;
        logic div_done;
    } status_t;

endpackage

// File: sv/moving_average_rotate_pair_core.sv
// top level of the moving average and rotate block
// depends on mar_pkg, mar_ctrl, mar_dpath
//
//  channel | valid      | stall      | payload
//  in      | in_valid   | in_stall   | sample_rp, sample_l
//  out     | out_valid  | out_stall  | filtered_rp/l, rotated_rp/l
//  cfg     | cfg_we     | -          | cfg_index, cfg_data
//
// one item at a time: in_stall stays high from the accepted input until the result
// is loaded into the output register; n the entries averaged (the window, or the
// fill count during warm-up); the ring walk reads one entry a cycle and the divider
// retires one quotient bit a cycle
// reset clears pointers, fill count, state and config registers; ring contents and data registers stay unset
// a held result in the output register blocks the next result, and the input while that result waits
module moving_average_rotate_pair_core
    import mar_pkg::*;
#(
    parameter int RING_DEPTH   = 512,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_rp,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_l,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] filtered_rp,
    output logic signed [SAMPLE_WIDTH-1:0] filtered_l,
    output logic signed [SAMPLE_WIDTH-1:0] rotated_rp,
    output logic signed [SAMPLE_WIDTH-1:0] rotated_l,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]        cfg_data
);

    cmd_t    cmd;
    status_t status;

    mar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    mar_dpath #(.RING_DEPTH(RING_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_rp   (sample_rp),
        .sample_l    (sample_l),
        .filtered_rp (filtered_rp),
        .filtered_l  (filtered_l),
        .rotated_rp  (rotated_rp),
        .rotated_l   (rotated_l)
    );

    // an accepted transfer always starts the ring write next cycle
    a_accept_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> cmd.ring_write)
        else $error("accepted item did not write ring");

    // the divider is never restarted mid-walk without a read end
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> status.read_last)
        else $error("divide started before window walk ended");

    // a result is loaded only when the output register is free
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("output overwritten while stalled");

endmodule

// File: sv/mar_ram.sv
// generic single port write, single port read ram with registered read
// no dependencies
module mar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/mar_div.sv
// restoring divider, signed dividend by unsigned divisor, truncating
// one quotient bit a cycle; no dependencies
module mar_div #(
    parameter int NUM_WIDTH = 41,
    parameter int DEN_WIDTH = 10,
    parameter int Q_WIDTH   = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [NUM_WIDTH-1:0] dividend,
    input  logic [DEN_WIDTH-1:0]        divisor,
    output logic                        done,
    output logic signed [Q_WIDTH-1:0]   quotient
);

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] quo_reg, quo_next;
    logic [DEN_WIDTH:0]   rem_reg, rem_next;
    logic [DEN_WIDTH-1:0] den_reg;
    logic                 neg_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DEN_WIDTH:0]   trial;
    logic [NUM_WIDTH-1:0] mag;
    logic [NUM_WIDTH-1:0] signed_q;

    assign mag = dividend[NUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;

    // shift in one dividend bit and try a subtract
    always_comb
    begin
        trial    = {rem_reg[DEN_WIDTH-1:0], quo_reg[NUM_WIDTH-1]};
        quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b0};
        rem_next = trial;
        if (trial >= {1'b0, den_reg})
        begin
            rem_next    = trial - {1'b0, den_reg};
            quo_next[0] = 1'b1;
        end
        cnt_next  = cnt_reg - 1'b1;
        busy_next = busy_reg && (cnt_reg != CW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_WIDTH);
            end
            else if (busy_reg)
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[NUM_WIDTH-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign signed_q = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient = signed_q[Q_WIDTH-1:0];

endmodule

// File: sv/mar_ctrl.sv
// controller state machine for the moving average and rotate block
// depends on mar_pkg
module mar_ctrl
    import mar_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_WRITE;
            ST_WRITE:   state_next = ST_READ;
            ST_READ:    state_next = ST_ACCUM;
            ST_ACCUM:   if (status.read_last) state_next = ST_DIVIDE;
            ST_DIVIDE:  if (status.div_done) state_next = ST_ROT_MUL;
            ST_ROT_MUL: state_next = ST_ROT_SUM;
            ST_ROT_SUM: state_next = ST_DONE;
            ST_DONE:    if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd            = '0;
        in_stall       = (state_reg != ST_IDLE);
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:    cmd.capture = in_valid;
            ST_WRITE:
            begin
                cmd.ring_write = 1'b1;
                cmd.read_start = 1'b1;
            end
            ST_READ:    cmd.read_step = 1'b1;
            ST_ACCUM:
            begin
                cmd.accum     = 1'b1;
                cmd.read_step = !status.read_last;
                cmd.div_start = status.read_last;
            end
            ST_DIVIDE:  ;
            ST_ROT_MUL: cmd.rot_mul = 1'b1;
            ST_ROT_SUM: cmd.rot_sum = 1'b1;
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/mar_dpath.sv
// datapath: rings, window sums, dividers, rotation and output register
// depends on mar_pkg, mar_ram and mar_div
module mar_dpath
    import mar_pkg::*;
#(
    parameter int RING_DEPTH   = 512,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmd_t                           cmd,
    output status_t                        status,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]        cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_rp,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_l,
    output logic signed [SAMPLE_WIDTH-1:0] filtered_rp,
    output logic signed [SAMPLE_WIDTH-1:0] filtered_l,
    output logic signed [SAMPLE_WIDTH-1:0] rotated_rp,
    output logic signed [SAMPLE_WIDTH-1:0] rotated_l
);

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int NW   = $clog2(RING_DEPTH + 1);
    localparam int SW   = SAMPLE_WIDTH + NW;
    localparam int DW   = SAMPLE_WIDTH + 1;
    localparam int PW   = DW + COEF_WIDTH;
    localparam int RW   = PW + 1;
    localparam int CFGW = (NW > 10) ? NW : 10;

    // configuration registers
    logic [NW-1:0]                  window_reg;
    logic                           rot_en_reg;
    logic signed [COEF_WIDTH-1:0]   cos_reg, sin_reg;
    logic signed [SAMPLE_WIDTH-1:0] ctr_rp_reg, ctr_l_reg;
    logic [CFGW-1:0]                win_raw;

    assign win_raw = CFGW'(cfg_data[9:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= NW'(25);
            rot_en_reg <= 1'b0;
            cos_reg    <= 16'sd32767;
            sin_reg    <= '0;
            ctr_rp_reg <= '0;
            ctr_l_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW:
                begin
                    if (win_raw == '0)
                        window_reg <= NW'(1);
                    else if (win_raw > CFGW'(RING_DEPTH))
                        window_reg <= NW'(RING_DEPTH);
                    else
                        window_reg <= NW'(win_raw);
                end
                REG_ROT_EN: rot_en_reg <= cfg_data[0];
                REG_COS:    cos_reg    <= cfg_data[COEF_WIDTH-1:0];
                REG_SIN:    sin_reg    <= cfg_data[COEF_WIDTH-1:0];
                REG_CTR_RP: ctr_rp_reg <= cfg_data;
                REG_CTR_L:  ctr_l_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // pointer, fill count and read walk
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [NW-1:0] fill_reg, n_reg, left_reg;
    logic [NW-1:0] fill_next;
    logic signed [SAMPLE_WIDTH-1:0] in_rp_reg, in_l_reg;

    assign fill_next = (fill_reg == NW'(RING_DEPTH)) ? fill_reg : fill_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            fill_reg <= '0;
            rptr_reg <= '0;
            n_reg    <= '0;
            left_reg <= '0;
        end
        else
        begin
            if (cmd.ring_write)
            begin
                wptr_reg <= (wptr_reg == AW'(RING_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                fill_reg <= fill_next;
            end
            if (cmd.read_start)
            begin
                rptr_reg <= wptr_reg;
                n_reg    <= (window_reg < fill_next) ? window_reg : fill_next;
                left_reg <= (window_reg < fill_next) ? window_reg : fill_next;
            end
            else if (cmd.read_step)
            begin
                rptr_reg <= (rptr_reg == '0) ? AW'(RING_DEPTH - 1) : rptr_reg - 1'b1;
                left_reg <= left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_rp_reg <= sample_rp;
            in_l_reg  <= sample_l;
        end
    end

    // ring memories
    logic [SAMPLE_WIDTH-1:0] rd_rp, rd_l;

    mar_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(RING_DEPTH)) u_ring_rp (
        .clk   (clk),
        .we    (cmd.ring_write),
        .waddr (wptr_reg),
        .wdata (in_rp_reg),
        .raddr (rptr_reg),
        .rdata (rd_rp)
    );

    mar_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(RING_DEPTH)) u_ring_l (
        .clk   (clk),
        .we    (cmd.ring_write),
        .waddr (wptr_reg),
        .wdata (in_l_reg),
        .raddr (rptr_reg),
        .rdata (rd_l)
    );

    // read data is registered behind the address, so the last read is at left==0
    assign status.read_last = (left_reg == '0);

    // window sums
    logic signed [SW-1:0] sum_rp_reg, sum_l_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.read_start)
        begin
            sum_rp_reg <= '0;
            sum_l_reg  <= '0;
        end
        else if (cmd.accum)
        begin
            sum_rp_reg <= sum_rp_reg + SW'($signed(rd_rp));
            sum_l_reg  <= sum_l_reg + SW'($signed(rd_l));
        end
    end

    // dividers, one per channel
    logic                           done_rp, done_l;
    logic signed [SAMPLE_WIDTH-1:0] q_rp, q_l;
    logic signed [SW-1:0]           div_in_rp, div_in_l;

    assign div_in_rp = sum_rp_reg + SW'($signed(rd_rp));
    assign div_in_l  = sum_l_reg + SW'($signed(rd_l));

    mar_div #(.NUM_WIDTH(SW), .DEN_WIDTH(NW), .Q_WIDTH(SAMPLE_WIDTH)) u_div_rp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_in_rp),
        .divisor  (n_reg),
        .done     (done_rp),
        .quotient (q_rp)
    );

    mar_div #(.NUM_WIDTH(SW), .DEN_WIDTH(NW), .Q_WIDTH(SAMPLE_WIDTH)) u_div_l (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_in_l),
        .divisor  (n_reg),
        .done     (done_l),
        .quotient (q_l)
    );

    assign status.div_done = done_rp && done_l;

    // rotation: products registered, then sum, shift and saturate; quotient passed through when rotation is off
    logic signed [DW-1:0] dx, dy;
    logic signed [PW-1:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [RW-1:0] s_rp, s_l, t_rp, t_l;
    logic signed [SAMPLE_WIDTH-1:0] rot_rp_reg, rot_l_reg;
    logic signed [SAMPLE_WIDTH-1:0] smax, smin;

    assign dx   = DW'(q_rp) - DW'(ctr_rp_reg);
    assign dy   = DW'(q_l) - DW'(ctr_l_reg);
    assign smax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    assign smin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    always_ff @(posedge clk)
    begin
        if (cmd.rot_mul)
        begin
            p_xc_reg <= PW'(dx) * PW'(cos_reg);
            p_ys_reg <= PW'(dy) * PW'(sin_reg);
            p_xs_reg <= PW'(dx) * PW'(sin_reg);
            p_yc_reg <= PW'(dy) * PW'(cos_reg);
        end
    end

    always_comb
    begin
        s_rp = (RW'(p_xc_reg) - RW'(p_ys_reg)) >>> ROT_SHIFT;
        s_l  = (RW'(p_xs_reg) + RW'(p_yc_reg)) >>> ROT_SHIFT;
        t_rp = s_rp + RW'(ctr_rp_reg);
        t_l  = s_l + RW'(ctr_l_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rot_sum)
        begin
            if (!rot_en_reg)
                rot_rp_reg <= q_rp;
            else if (t_rp > RW'(smax))
                rot_rp_reg <= smax;
            else if (t_rp < RW'(smin))
                rot_rp_reg <= smin;
            else
                rot_rp_reg <= t_rp[SAMPLE_WIDTH-1:0];
            if (!rot_en_reg)
                rot_l_reg <= q_l;
            else if (t_l > RW'(smax))
                rot_l_reg <= smax;
            else if (t_l < RW'(smin))
                rot_l_reg <= smin;
            else
                rot_l_reg <= t_l[SAMPLE_WIDTH-1:0];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            filtered_rp <= q_rp;
            filtered_l  <= q_l;
            rotated_rp  <= rot_rp_reg;
            rotated_l   <= rot_l_reg;
        end
    end

endmodule
